[rtl/ksa_pkg.sv]
// Shared types and constants for the key slot allocator.
// No dependencies; every other file refers to this package by scoped names.
package ksa_pkg;

  localparam int KEY_W   = 16;
  localparam int IDX_W   = 8;
  localparam int SLOT_W  = 5;
  localparam int EPOCH_W = 32;

  typedef enum logic [1:0] {
    CMD_ACQUIRE     = 2'd0,
    CMD_RELEASE     = 2'd1,
    CMD_RELEASE_ALL = 2'd2,
    CMD_QUERY       = 2'd3
  } cmd_t;

  // Which slot the epoch memory read port addresses
  typedef enum logic [1:0] {
    EP_SLOT0,
    EP_PICK,
    EP_QUERY
  } ep_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic    take;      // input channel ready
    logic    claim0;    // claim slot 0 for the default key
    logic    ep_rd;     // read epoch memory, remember the address
    ep_sel_t ep_sel;
    logic    ep_bump;   // write back the bumped epoch at the remembered address
    logic    exec;      // apply acquire / release / release-all to the table
    logic    query;     // capture the query result
    logic    out_load;  // move the result into the output register
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic used0;
    logic need_bump;
    logic out_busy;
  } stat_t;

endpackage

[rtl/ksa_req_if.sv]
// Request channel: command, key and slot index with valid/ready.
// Depends on ksa_pkg.
interface ksa_req_if;
  logic                       valid;
  logic                       ready;
  ksa_pkg::cmd_t              cmd;
  logic [ksa_pkg::KEY_W-1:0]  key;
  logic [ksa_pkg::IDX_W-1:0]  slot_index;

  modport source(output valid, cmd, key, slot_index, input ready);
  modport sink(input valid, cmd, key, slot_index, output ready);
endinterface

[rtl/ksa_rsp_if.sv]
// Response channel: ok flag, slot and epoch with valid/ready.
// Depends on ksa_pkg.
interface ksa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [ksa_pkg::SLOT_W-1:0]   slot;
  logic [ksa_pkg::EPOCH_W-1:0]  epoch;

  modport source(output valid, ok, slot, epoch, input ready);
  modport sink(input valid, ok, slot, epoch, output ready);
endinterface

[rtl/ksa_cfg_if.sv]
// Configuration write channel for the default key register.
// Depends on ksa_pkg.
interface ksa_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ksa_pkg::KEY_W-1:0]  default_key;

  modport source(output valid, default_key, input ready);
  modport sink(input valid, default_key, output ready);
endinterface

[rtl/key_slot_allocator_with_epochs.sv]
// Top level of the keyed slot allocator with per-slot epochs.
// Depends on ksa_pkg, ksa_req_if, ksa_rsp_if, ksa_cfg_if, ksa_ctrl and ksa_dp.
//
//   channel  dir  payload                         accepted when
//   req      in   cmd, key, slot_index            req.valid && req.ready
//   rsp      out  ok, slot, epoch                 rsp.valid && rsp.ready
//   cfg      in   default_key                     cfg.valid && cfg.ready
//
// One transaction at a time: a query reads the epoch memory, then takes the result;
// acquire/release/release-all first claim slot 0 when it is free, then execute, and
// a claim or new acquire slot bumps its epoch in the registered-read epoch memory.
// Synchronous active-high reset frees every slot and zeroes every epoch at once.
// A result waits in the output register while rsp stalls; the next request
// is taken once the pending result has moved there. req and cfg are not ready
// during reset; cfg is ready at every other cycle.
module key_slot_allocator_with_epochs #(
  parameter int SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  ksa_req_if.sink    req,
  ksa_rsp_if.source  rsp,
  ksa_cfg_if.sink    cfg
);

  ksa_pkg::ctl_t  ctl;
  ksa_pkg::stat_t stat;

  assign req.ready = ctl.take && !rst;
  assign cfg.ready = !rst;

  ksa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .stat      (stat),
    .ctl       (ctl)
  );

  ksa_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .stat            (stat),
    .req_accept      (req.valid && ctl.take && !rst),
    .req_cmd         (req.cmd),
    .req_key         (req.key),
    .req_slot_index  (req.slot_index),
    .cfg_we          (cfg.valid),
    .cfg_default_key (cfg.default_key),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_ok          (rsp.ok),
    .rsp_slot        (rsp.slot),
    .rsp_epoch       (rsp.epoch)
  );

endmodule

[rtl/ksa_ctrl.sv]
// Sequencer for the key slot allocator: one transaction at a time.
// Depends on ksa_pkg; drives ksa_dp through ctl_t and reads stat_t.
module ksa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  ksa_pkg::cmd_t   req_cmd,
  input  ksa_pkg::stat_t  stat,
  output ksa_pkg::ctl_t   ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAIM,
    S_CLAIM_WR,
    S_EXEC,
    S_BUMP_WR,
    S_QRD,
    S_QRES,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    ctl.ep_sel = ksa_pkg::EP_SLOT0;
    state_next = state;
    case (state)
      S_IDLE: begin
        ctl.take = 1'b1;
        if (req_valid) begin
          state_next = (req_cmd == ksa_pkg::CMD_QUERY) ? S_QRD : S_CLAIM;
        end
      end
      S_CLAIM: begin
        if (!stat.used0) begin
          ctl.claim0 = 1'b1;
          ctl.ep_rd  = 1'b1;
          ctl.ep_sel = ksa_pkg::EP_SLOT0;
          state_next = S_CLAIM_WR;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_CLAIM_WR: begin
        ctl.ep_bump = 1'b1;
        state_next  = S_EXEC;
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        if (stat.need_bump) begin
          ctl.ep_rd  = 1'b1;
          ctl.ep_sel = ksa_pkg::EP_PICK;
          state_next = S_BUMP_WR;
        end else begin
          state_next = S_DONE;
        end
      end
      S_BUMP_WR: begin
        ctl.ep_bump = 1'b1;
        state_next  = S_DONE;
      end
      S_QRD: begin
        ctl.ep_rd  = 1'b1;
        ctl.ep_sel = ksa_pkg::EP_QUERY;
        state_next = S_QRES;
      end
      S_QRES: begin
        ctl.query  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (!stat.out_busy) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/ksa_dp.sv]
// Datapath of the key slot allocator: slot table, epoch memory, result registers.
// Depends on ksa_pkg; sequenced by ksa_ctrl.
module ksa_dp #(
  parameter int SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ksa_pkg::ctl_t                 ctl,
  output ksa_pkg::stat_t                stat,
  input  logic                          req_accept,
  input  ksa_pkg::cmd_t                 req_cmd,
  input  logic [ksa_pkg::KEY_W-1:0]     req_key,
  input  logic [ksa_pkg::IDX_W-1:0]     req_slot_index,
  input  logic                          cfg_we,
  input  logic [ksa_pkg::KEY_W-1:0]     cfg_default_key,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic                          rsp_ok,
  output logic [ksa_pkg::SLOT_W-1:0]    rsp_slot,
  output logic [ksa_pkg::EPOCH_W-1:0]   rsp_epoch
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [ksa_pkg::SLOT_W-1:0] FULL_SLOT = ksa_pkg::SLOT_W'(SLOTS % 32);

  // latched transaction
  ksa_pkg::cmd_t               cmd_r;
  logic [ksa_pkg::KEY_W-1:0]   key_r;
  logic [ksa_pkg::IDX_W-1:0]   idx_r;
  logic [ksa_pkg::KEY_W-1:0]   default_key;

  // slot table
  logic [SLOTS-1:0]            used;
  logic [ksa_pkg::KEY_W-1:0]   keys [SLOTS];

  // epoch memory, an entry never written reads as zero
  logic [ksa_pkg::EPOCH_W-1:0] ep_mem [SLOTS];
  logic [SLOTS-1:0]            ep_vld;
  logic [ksa_pkg::EPOCH_W-1:0] ep_q;
  logic                        ep_vq;
  logic [IW-1:0]               ep_addr;
  logic [IW-1:0]               ep_ra;
  logic                        ep_re;
  logic                        q_in_range;
  logic [ksa_pkg::EPOCH_W-1:0] ep_cur;
  logic [ksa_pkg::EPOCH_W-1:0] bump_val;

  // search results
  logic                        hit;
  logic [IW-1:0]               hit_idx;
  logic                        free;
  logic [IW-1:0]               free_idx;
  logic                        is_acq;

  // result
  logic                        res_ok;
  logic [ksa_pkg::SLOT_W-1:0]  res_slot;
  logic [ksa_pkg::EPOCH_W-1:0] res_epoch;

  always_ff @(posedge clk) begin
    if (req_accept) begin
      cmd_r <= req_cmd;
      key_r <= req_key;
      idx_r <= req_slot_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_key <= '0;
    end else if (cfg_we) begin
      default_key <= cfg_default_key;
    end
  end

  // lowest used slot with a matching key, lowest free slot from 1 up
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free     = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (used[i] && keys[i] == key_r) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
    for (int i = SLOTS - 1; i >= 1; i--) begin
      if (!used[i]) begin
        free     = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign is_acq = (cmd_r == ksa_pkg::CMD_ACQUIRE);

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      if (ctl.claim0) begin
        used[0] <= 1'b1;
      end
      if (ctl.exec) begin
        case (cmd_r)
          ksa_pkg::CMD_ACQUIRE: begin
            if (!hit && free) begin
              used[free_idx] <= 1'b1;
            end
          end
          ksa_pkg::CMD_RELEASE: begin
            // the default key is never released
            if (key_r != default_key && hit) begin
              used[hit_idx] <= 1'b0;
            end
          end
          ksa_pkg::CMD_RELEASE_ALL: begin
            for (int i = 1; i < SLOTS; i++) begin
              used[i] <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.claim0) begin
      keys[0] <= default_key;
    end
    if (ctl.exec && is_acq && !hit && free) begin
      keys[free_idx] <= key_r;
    end
  end

  // epoch read-modify-write through one read and one write port
  assign q_in_range = (32'(idx_r) < SLOTS);

  always_comb begin
    case (ctl.ep_sel)
      ksa_pkg::EP_SLOT0: ep_ra = '0;
      ksa_pkg::EP_PICK:  ep_ra = free_idx;
      ksa_pkg::EP_QUERY: ep_ra = IW'(idx_r);
      default:           ep_ra = '0;
    endcase
  end

  assign ep_re    = ctl.ep_rd && (ctl.ep_sel != ksa_pkg::EP_QUERY || q_in_range);
  assign ep_cur   = ep_vq ? ep_q : '0;
  assign bump_val = (ep_cur == '1) ? ksa_pkg::EPOCH_W'(1) : ep_cur + 1'b1;

  always_ff @(posedge clk) begin
    if (ctl.ep_bump) begin
      ep_mem[ep_addr] <= bump_val;
    end
    if (ep_re) begin
      ep_q <= ep_mem[ep_ra];
    end
    if (ctl.ep_rd) begin
      ep_addr <= ep_ra;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ep_vld <= '0;
      ep_vq  <= 1'b0;
    end else begin
      if (ctl.ep_bump) begin
        ep_vld[ep_addr] <= 1'b1;
      end
      if (ctl.ep_rd) begin
        ep_vq <= ep_re ? ep_vld[ep_ra] : 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      res_ok    <= is_acq && (hit || free);
      res_epoch <= '0;
      if (!is_acq) begin
        res_slot <= '0;
      end else if (hit) begin
        res_slot <= ksa_pkg::SLOT_W'(hit_idx);
      end else if (free) begin
        res_slot <= ksa_pkg::SLOT_W'(free_idx);
      end else begin
        res_slot <= FULL_SLOT;
      end
    end
    if (ctl.query) begin
      res_ok    <= 1'b0;
      res_slot  <= '0;
      res_epoch <= ep_cur;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      rsp_ok    <= res_ok;
      rsp_slot  <= res_slot;
      rsp_epoch <= res_epoch;
    end
  end

  assign stat.used0     = used[0];
  assign stat.need_bump = is_acq && !hit && free;
  assign stat.out_busy  = rsp_valid && !rsp_ready;

endmodule
